// File: rtl/buzzer_melody_sequencer_assert.svh
// Assertion macros used by the buzzer melody sequencer RTL.
`ifndef BUZZER_MELODY_SEQUENCER_ASSERT_SVH
`define BUZZER_MELODY_SEQUENCER_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define BMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/bms_pkg.sv
// Types, constants and helper functions of the buzzer melody sequencer.
`default_nettype none
package bms_pkg;

  localparam int NOTE_DEPTH = 256;
  localparam int ADDR_W     = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int OP_W       = 3;
  localparam int FREQ_W     = 16;
  localparam int MS_W       = 16;
  localparam int TICKS_W    = 14;
  localparam int POS_W      = 8;
  localparam int IDX_W      = 8;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  localparam int DIV5_MUL   = 52429;
  localparam int DIV5_SHIFT = 18;
  localparam int PROD_W     = MS_W + 18;

  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_START = 3'd2;
  localparam logic [OP_W-1:0] OP_PLAY  = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

  typedef struct packed {
    logic [TICKS_W-1:0] ticks;
    logic [FREQ_W-1:0]  freq;
  } bms_entry_t;

  localparam int ENTRY_W = $bits(bms_entry_t);

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FREQ_W-1:0]  freq;
    logic [TICKS_W-1:0] ticks;
    logic [TICKS_W-1:0] gap_ticks;
    logic [POS_W-1:0]   len;
  } bms_item_t;

  // Milliseconds to 5 ms ticks, truncating, by a reciprocal multiply.
  function automatic logic [TICKS_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(ms) * PROD_W'(DIV5_MUL);
    return prod[DIV5_SHIFT +: TICKS_W];
  endfunction

endpackage
`default_nettype wire

// File: rtl/bms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/bms_exec.sv
// Sequencer state update and the registered result beat.
`default_nettype none
`include "buzzer_melody_sequencer_assert.svh"
module bms_exec (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         item_valid,
  input  wire bms_pkg::bms_item_t           item,
  input  wire bms_pkg::bms_entry_t          entry,
  output logic                              item_take,
  output logic [bms_pkg::POS_W-1:0]         pos_nxt,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // Fields from bit 0: tone_on, tone_freq[15:0], note_playing, song_active, zero fill.
  output logic [bms_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import bms_pkg::*;

  logic [TICKS_W-1:0]    note_r, note_nxt;
  logic [TICKS_W-1:0]    gap_r, gap_nxt;
  logic [TICKS_W-1:0]    gap_reload_r, gap_reload_nxt;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      len_r, len_nxt;
  logic                  running_r, running_nxt;
  logic                  tone_en_r, tone_en_nxt;
  logic [FREQ_W-1:0]     freq_r, freq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [POS_W:0]        pos_inc;

  assign item_take = item_valid && (!out_valid_r || out_tready);
  assign pos_inc   = {1'b0, pos_r} + (POS_W + 1)'(1);

  always_comb begin
    note_nxt       = note_r;
    gap_nxt        = gap_r;
    gap_reload_nxt = gap_reload_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    running_nxt    = running_r;
    tone_en_nxt    = tone_en_r;
    freq_nxt       = freq_r;
    if (item_take) begin
      unique case (item.op)
        OP_TICK: begin
          if (note_r != '0) begin
            note_nxt = note_r - TICKS_W'(1);
            if (note_r == TICKS_W'(1)) begin
              gap_nxt     = gap_reload_r;
              tone_en_nxt = 1'b0;
            end
          end else if (gap_r != '0) begin
            gap_nxt = gap_r - TICKS_W'(1);
          end else if (running_r) begin
            freq_nxt    = entry.freq;
            tone_en_nxt = 1'b1;
            note_nxt    = entry.ticks;
            if (pos_inc >= {1'b0, len_r}) begin
              running_nxt = 1'b0;
              pos_nxt     = '0;
              len_nxt     = '0;
            end else begin
              pos_nxt = pos_inc[POS_W-1:0];
            end
          end
        end
        OP_START: begin
          if (len_r == '0) begin
            len_nxt        = item.len;
            pos_nxt        = '0;
            running_nxt    = 1'b1;
            gap_reload_nxt = item.gap_ticks;
            freq_nxt       = entry.freq;
            tone_en_nxt    = 1'b1;
            note_nxt       = entry.ticks;
          end
        end
        OP_PLAY: begin
          freq_nxt    = item.freq;
          tone_en_nxt = 1'b1;
          note_nxt    = item.ticks;
        end
        OP_STOP: begin
          note_nxt    = '0;
          tone_en_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_data_nxt = {(OUT_DATA_W - FREQ_W - 3)'(0), running_nxt, (note_nxt != '0),
                    freq_nxt, tone_en_nxt};
    if (item_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_r       <= '0;
      gap_r        <= '0;
      gap_reload_r <= '0;
      pos_r        <= '0;
      len_r        <= '0;
      running_r    <= 1'b0;
      tone_en_r    <= 1'b0;
      freq_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      note_r       <= note_nxt;
      gap_r        <= gap_nxt;
      gap_reload_r <= gap_reload_nxt;
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      running_r    <= running_nxt;
      tone_en_r    <= tone_en_nxt;
      freq_r       <= freq_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `BMS_ASSERT(a_len_implies_running, (len_r != '0) |-> running_r, "song length held without a running song")
  `BMS_ASSERT(a_note_implies_tone, (note_r != '0) |-> tone_en_r, "note counting with the tone disabled")
  `BMS_ASSERT(a_pos_in_song, (pos_r == '0) || (pos_r < len_r), "song position beyond song length")
  `BMS_ASSERT(a_take_gives_beat, item_take |=> out_valid_r, "executed item produced no result beat")

endmodule
`default_nettype wire

// File: rtl/buzzer_melody_sequencer.sv
// Top level of the buzzer melody sequencer: input register, note store and sequencer.
//
//   Channel   Direction   Handshake               Payload
//   in_       slave       in_tvalid / in_tready    in_tuser opcode, in_tdata note fields
//   out_      master      out_tvalid / out_tready  out_tdata tone status
//
// Each command beat yields one status beat; one beat per cycle is sustained while out_tready stays high.
// A command passes the input register, with the note store read, and then the registered state update.
// The note store is a RAM with a registered read; its contents are undefined after reset.
// Reset is synchronous and active low and clears all sequencer state.
// A stalled output holds its beat while one more command waits in the input register.
`default_nettype none
module buzzer_melody_sequencer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: entry_index[7:0], note_freq[15:0], note_ms[15:0], gap_ms[15:0],
  // song_length[7:0].
  input  wire logic [bms_pkg::IN_DATA_W-1:0]   in_tdata,
  // Fields from bit 0: opcode[2:0].
  input  wire logic [bms_pkg::OP_W-1:0]        in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // Fields from bit 0: tone_on, tone_freq[15:0], note_playing, song_active, zero fill.
  output logic [bms_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import bms_pkg::*;

  logic [IDX_W-1:0]   in_idx;
  logic [FREQ_W-1:0]  in_freq;
  logic [MS_W-1:0]    in_ms;
  logic [MS_W-1:0]    in_gap;
  logic [POS_W-1:0]   in_len;
  logic [TICKS_W-1:0] in_ticks;
  logic               in_accept;
  logic               item_take;
  logic [POS_W-1:0]   pos_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  bms_item_t          s1_item_r;
  logic               rd_oob_r;
  logic               wr_en;
  logic               rd_oob_nxt;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  bms_entry_t         wr_entry;
  bms_entry_t         entry;

  assign in_idx   = in_tdata[0 +: IDX_W];
  assign in_freq  = in_tdata[IDX_W +: FREQ_W];
  assign in_ms    = in_tdata[IDX_W + FREQ_W +: MS_W];
  assign in_gap   = in_tdata[IDX_W + FREQ_W + MS_W +: MS_W];
  assign in_len   = in_tdata[IDX_W + FREQ_W + 2 * MS_W +: POS_W];
  assign in_ticks = ms_to_ticks(in_ms);

  assign in_tready = !s1_valid_r || item_take;
  assign in_accept = in_tvalid && in_tready;

  assign wr_en = in_accept && (in_tuser == OP_WRITE) &&
                 ({1'b0, in_idx} < (IDX_W + 1)'(NOTE_DEPTH));
  assign wr_entry.ticks = in_ticks;
  assign wr_entry.freq  = in_freq;

  always_comb begin
    if (in_tuser == OP_START) begin
      rd_addr    = '0;
      rd_oob_nxt = 1'b0;
    end else begin
      rd_addr    = pos_nxt[ADDR_W-1:0];
      rd_oob_nxt = ({1'b0, pos_nxt} >= (POS_W + 1)'(NOTE_DEPTH));
    end
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (item_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.op        <= in_tuser;
      s1_item_r.freq      <= in_freq;
      s1_item_r.ticks     <= in_ticks;
      s1_item_r.gap_ticks <= ms_to_ticks(in_gap);
      s1_item_r.len       <= in_len;
      rd_oob_r            <= rd_oob_nxt;
    end
  end

  bms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NOTE_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_note_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(in_idx[ADDR_W-1:0]),
    .wdata(wr_entry),
    .re   (in_accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign entry = rd_oob_r ? bms_entry_t'('0) : bms_entry_t'(rd_data);

  bms_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(s1_valid_r),
    .item      (s1_item_r),
    .entry     (entry),
    .item_take (item_take),
    .pos_nxt   (pos_nxt),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire
